@@ sv/assert_macros.svh @@
// assertion macros used by the top-level interleaver unit
// no dependencies; the bodies compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds in every cycle out of reset
`define DRFI_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: always");

// antecedent implies consequent in the same cycle
`define DRFI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define DRFI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define DRFI_ASSERT_ALWAYS(label, clk, rst, cond)
`define DRFI_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DRFI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/drfi_pkg.sv @@
// shared types, constants and helpers of the dual ring fifo interleaver
// no dependencies
package drfi_pkg;

   localparam int DEPTH  = 32;
   localparam int DATA_W = 32;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_REMOVE     = 2'd1,
      OP_INTERLEAVE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_WALK
   } fsm_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic do_insert;
      logic do_remove;
      logic do_empty;
      logic walk_init;
      logic walk_step;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       both_empty;
      logic       walk_last;
   } dp_status_type;

   // ring pointer increment with wrap at DEPTH
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

@@ sv/drfi_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module drfi_ram #(
   parameter int WIDTH = 32,
   parameter int WORDS = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/drfi_datapath.sv @@
// datapath: queue pointers and counts, two queue rams, walk counters, result register
// depends on drfi_pkg and drfi_ram
module drfi_datapath
   import drfi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        st,
   input  logic [1:0]           req_operation,
   input  logic                 req_queue_select,
   input  logic signed [31:0]   req_data_in,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_data_out,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);

   logic [1:0]        op_ff, op_in;
   logic              sel_ff, sel_in;
   logic [DATA_W-1:0] word_ff, word_in;

   logic [PTR_W-1:0]  head_ff [2];
   logic [PTR_W-1:0]  head_in [2];
   logic [PTR_W-1:0]  tail_ff [2];
   logic [PTR_W-1:0]  tail_in [2];
   logic [CNT_W-1:0]  count_ff [2];
   logic [CNT_W-1:0]  count_in [2];

   logic [PTR_W-1:0]  wptr_ff [2];
   logic [PTR_W-1:0]  wptr_in [2];
   logic [CNT_W-1:0]  wleft_ff [2];
   logic [CNT_W-1:0]  wleft_in [2];
   logic              turn_ff, turn_in;

   logic              rd_pend_ff, rd_pend_in;
   logic              rd_src_ff, rd_src_in;
   logic              rd_last_ff, rd_last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              full, empty, pick, walk_last;
   logic [CNT_W:0]    wleft_sum;
   logic [PTR_W-1:0]  rd_addr;
   logic              we_a, we_b;
   logic [DATA_W-1:0] q_a, q_b;

   drfi_ram #(.WIDTH(DATA_W), .WORDS(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (tail_ff[0]),
      .wr_data (word_ff),
      .rd_addr (rd_addr),
      .rd_data (q_a)
   );

   drfi_ram #(.WIDTH(DATA_W), .WORDS(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (tail_ff[1]),
      .wr_data (word_ff),
      .rd_addr (rd_addr),
      .rd_data (q_b)
   );

   assign full      = (count_ff[sel_ff] == CNT_W'(DEPTH));
   assign empty     = (count_ff[sel_ff] == '0);
   assign wleft_sum = {1'b0, wleft_ff[0]} + {1'b0, wleft_ff[1]};
   assign walk_last = (wleft_sum == (CNT_W+1)'(1));
   // b then a while both have words, then whichever is left
   assign pick      = ((wleft_ff[0] != '0) && (wleft_ff[1] != '0)) ? turn_ff
                                                                   : (wleft_ff[1] != '0);

   assign we_a = cmd.do_insert && !full && !sel_ff;
   assign we_b = cmd.do_insert && !full && sel_ff;

   always_comb begin
      op_in         = op_ff;
      sel_in        = sel_ff;
      word_in       = word_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      wptr_in       = wptr_ff;
      wleft_in      = wleft_ff;
      turn_in       = turn_ff;
      rd_addr       = head_ff[sel_ff];
      rd_pend_in    = 1'b0;
      rd_src_in     = rd_src_ff;
      rd_last_in    = rd_last_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.capture) begin
         op_in   = req_operation;
         sel_in  = req_queue_select;
         word_in = req_data_in;
      end

      // read issued last cycle, ram output now valid
      if (rd_pend_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = rd_src_ff ? q_b : q_a;
         rsp_status_in = ST_OK;
         rsp_last_in   = rd_last_ff;
      end

      if (cmd.do_insert) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_last_in  = 1'b1;
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in    = ST_OK;
            tail_in[sel_ff]  = next_ptr(tail_ff[sel_ff]);
            count_in[sel_ff] = count_ff[sel_ff] + CNT_W'(1);
         end
      end

      if (cmd.do_remove) begin
         if (empty) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = '0;
            rsp_status_in = ST_EMPTY;
            rsp_last_in   = 1'b1;
         end else begin
            rd_pend_in       = 1'b1;
            rd_src_in        = sel_ff;
            rd_last_in       = 1'b1;
            head_in[sel_ff]  = next_ptr(head_ff[sel_ff]);
            count_in[sel_ff] = count_ff[sel_ff] - CNT_W'(1);
         end
      end

      if (cmd.do_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = ST_EMPTY;
         rsp_last_in   = 1'b1;
      end

      if (cmd.walk_init) begin
         wptr_in  = head_ff;
         wleft_in = count_ff;
         turn_in  = 1'b1;
      end

      if (cmd.walk_step) begin
         rd_addr        = wptr_ff[pick];
         rd_pend_in     = 1'b1;
         rd_src_in      = pick;
         rd_last_in     = walk_last;
         wptr_in[pick]  = next_ptr(wptr_ff[pick]);
         wleft_in[pick] = wleft_ff[pick] - CNT_W'(1);
         turn_in        = ~pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '{default: '0};
         tail_ff      <= '{default: '0};
         count_ff     <= '{default: '0};
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      sel_ff        <= sel_in;
      word_ff       <= word_in;
      wptr_ff       <= wptr_in;
      wleft_ff      <= wleft_in;
      turn_ff       <= turn_in;
      rd_src_ff     <= rd_src_in;
      rd_last_ff    <= rd_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign st.op         = op_ff;
   assign st.both_empty = (count_ff[0] == '0) && (count_ff[1] == '0);
   assign st.walk_last  = walk_last;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

@@ sv/drfi_ctrl.sv @@
// controller: sequences insert, remove and the interleave walk
// depends on drfi_pkg
module drfi_ctrl
   import drfi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type st,
   output dp_cmd_type    cmd
);

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            state_in = FSM_IDLE;
            case (st.op)
               OP_INSERT: begin
                  cmd.do_insert = 1'b1;
               end
               OP_REMOVE: begin
                  cmd.do_remove = 1'b1;
               end
               OP_INTERLEAVE: begin
                  if (st.both_empty) begin
                     cmd.do_empty = 1'b1;
                  end else begin
                     cmd.walk_init = 1'b1;
                     state_in      = FSM_WALK;
                  end
               end
               default: begin
                  // unused code: no result
                  state_in = FSM_IDLE;
               end
            endcase
         end
         FSM_WALK: begin
            cmd.walk_step = 1'b1;
            if (st.walk_last) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

@@ sv/dual_ring_fifo_interleaver_unit.sv @@
// results: insert, empty remove and empty interleave results are registered from the execute
// state; a remove returns its word through the ram read register and then the result register;
// an interleave strobes its words through the same two registers, one word every cycle
// throughput: the controller steps one ram read per cycle and takes a new request only in idle;
// the receiver cannot stall, a result shows for one cycle
// reset: synchronous, clears head and tail pointers, counts and control; queue rams are not cleared
`include "assert_macros.svh"

module dual_ring_fifo_interleaver_unit
   import drfi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic               req_queue_select,
   input  logic signed [31:0] req_data_in,
   // result channel
   output logic               rsp_valid,
   output logic signed [31:0] rsp_data_out,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   // command and status between the controller and the datapath
   dp_cmd_type    cmd;
   dp_status_type st;

   // datapath operations requested this cycle, for the one-hot check
   logic [4:0]    dp_ops;

   // controller: idle, execute one transaction, or walk both queues for an interleave
   drfi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   // datapath: the two rings, their rams, the walk pointers and the result register
   drfi_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_operation    (req_operation),
      .req_queue_select (req_queue_select),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_data_out     (rsp_data_out),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   assign dp_ops = {cmd.do_insert, cmd.do_remove, cmd.do_empty, cmd.walk_init, cmd.walk_step};

   // at most one datapath operation per cycle
   `DRFI_ASSERT_ALWAYS(a_one_cmd, clock, reset, $onehot0(dp_ops))

   // an accepted transaction makes the block busy
   `DRFI_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // an interleave stream has no gaps until its last word
   `DRFI_ASSERT_NEXT(a_stream_dense, clock, reset, rsp_valid && !rsp_last, rsp_valid)

   // full and empty statuses always close their transaction
   `DRFI_ASSERT_IMPLY(a_err_last, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_last)

endmodule
